FILE: design/rrss_pkg.sv
package rrss_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int SLICE_W = 8;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;

    // Command codes carried in the cmd field of a request word.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SLICE = 1'b1;

    // Status codes of a response word.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd10;

    // One ready-queue entry.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
    } entry_t;

endpackage

FILE: design/rrss_req_if.sv
interface rrss_req_if;

    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [rrss_pkg::ID_W-1:0]    task_id;
    logic [rrss_pkg::BURST_W-1:0] burst;

    modport source (output valid, output cmd, output task_id, output burst, input ready);
    modport sink   (input valid, input cmd, input task_id, input burst, output ready);

endinterface

FILE: design/rrss_rsp_if.sv
interface rrss_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [rrss_pkg::STAT_W-1:0]  status;
    logic [rrss_pkg::ID_W-1:0]    ran_task_id;
    logic [rrss_pkg::SLICE_W-1:0] slice_length;
    logic [rrss_pkg::BURST_W-1:0] remaining_burst;
    logic                         finished;
    logic [rrss_pkg::TIME_W-1:0]  elapsed_time;

    modport source (
        output valid, output status, output ran_task_id, output slice_length,
        output remaining_burst, output finished, output elapsed_time, input ready
    );
    modport sink (
        input valid, input status, input ran_task_id, input slice_length,
        input remaining_burst, input finished, input elapsed_time, output ready
    );

endinterface

FILE: design/rrss_queue_mem.sv
// Ready-queue storage with one write and one registered read per cycle.
// A write to the address being read in the same cycle is forwarded, so the
// read data always shows the current contents of the read address.
module rrss_queue_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  rrss_pkg::entry_t      wr_entry,
    input  logic [AW-1:0]         rd_addr,
    output rrss_pkg::entry_t      rd_entry
);

    rrss_pkg::entry_t mem [DEPTH];
    rrss_pkg::entry_t rd_data_reg;
    rrss_pkg::entry_t byp_entry_reg;
    logic             byp_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg   <= mem[rd_addr];
        byp_entry_reg <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_sel_reg <= 1'b0;
        end
        else
        begin
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_entry = byp_sel_reg ? byp_entry_reg : rd_data_reg;

endmodule

FILE: design/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler.
// A word goes through the input register and then the response register.
// Throughput: one word per cycle absent response stalls, set by the head-of-queue read,
// refreshed every cycle through the memory's registered read port and write forwarding.
// Reset: queue empty, pointers and elapsed time zero, quantum 10; the queue memory
// itself is not cleared, since no entry is read before it is written.
module round_robin_slice_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    rrss_req_if.sink          req,
    rrss_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Register index of the quantum, taken from the word address bit.
    localparam logic REG_QUANTUM = 1'b0;

    // ------------------------------------------------------------------
    // Configuration port. Only the quantum exists; other addresses read
    // as zero and ignore writes.
    // ------------------------------------------------------------------
    logic [rrss_pkg::SLICE_W-1:0] quantum_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM);
    assign prdata = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrss_pkg::QUANTUM_RESET;
        end
        else if (cfg_wr)
        begin
            quantum_reg <= pwdata[rrss_pkg::SLICE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input register. A word waits here while the head of the queue is
    // read, then is processed in a single pass.
    // ------------------------------------------------------------------
    logic                         s1_valid_reg;
    logic                         s1_cmd_reg;
    logic [rrss_pkg::ID_W-1:0]    s1_id_reg;
    logic [rrss_pkg::BURST_W-1:0] s1_burst_reg;
    logic                         adv;
    logic                         req_acc;

    // The stage moves forward when the response register is free or drained.
    assign adv       = s1_valid_reg && (!rsp.valid || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;
    assign req_acc   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_cmd_reg   <= req.cmd;
            s1_id_reg    <= req.task_id;
            s1_burst_reg <= req.burst;
        end
    end

    // ------------------------------------------------------------------
    // Queue state: head and tail pointers, occupancy and elapsed time.
    // ------------------------------------------------------------------
    logic [AW-1:0]               head_ptr_reg, head_ptr_next;
    logic [AW-1:0]               tail_ptr_reg, tail_ptr_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [rrss_pkg::TIME_W-1:0] time_reg, time_next;

    logic             wr_en;
    rrss_pkg::entry_t wr_entry;
    rrss_pkg::entry_t head_entry;

    // The read address follows the head pointer's next value, so the
    // head entry is ready for the word processed in the following cycle.
    rrss_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (tail_ptr_reg),
        .wr_entry (wr_entry),
        .rd_addr  (head_ptr_next),
        .rd_entry (head_entry)
    );

    // ------------------------------------------------------------------
    // Single-pass scheduling decision.
    // ------------------------------------------------------------------
    logic                         q_full;
    logic                         q_empty;
    logic [rrss_pkg::SLICE_W-1:0] slice_len;
    logic [rrss_pkg::BURST_W-1:0] rem_burst;
    logic                         done;
    logic [AW-1:0]                head_inc;
    logic [AW-1:0]                tail_inc;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [rrss_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [rrss_pkg::ID_W-1:0]    ran_id_reg, ran_id_next;
    logic [rrss_pkg::SLICE_W-1:0] slice_reg, slice_next;
    logic [rrss_pkg::BURST_W-1:0] rem_reg, rem_next;
    logic                         fin_reg, fin_next;
    logic [rrss_pkg::TIME_W-1:0]  etime_reg, etime_next;

    assign q_full   = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign head_inc = (head_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_reg + AW'(1);
    assign tail_inc = (tail_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_reg + AW'(1);

    // The slice is the smaller of the remaining burst and the quantum, so
    // the subtraction never goes below zero.
    assign slice_len = (head_entry.burst < {8'd0, quantum_reg}) ?
                       head_entry.burst[rrss_pkg::SLICE_W-1:0] : quantum_reg;
    assign rem_burst = head_entry.burst - {8'd0, slice_len};
    assign done      = (rem_burst == '0);

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        time_next     = time_reg;
        wr_en         = 1'b0;
        wr_entry.id   = s1_id_reg;
        wr_entry.burst = s1_burst_reg;

        status_next = rrss_pkg::STATUS_OK;
        ran_id_next = '0;
        slice_next  = '0;
        rem_next    = '0;
        fin_next    = 1'b0;
        etime_next  = '0;

        if (adv)
        begin
            if (s1_cmd_reg == rrss_pkg::CMD_ADD)
            begin
                if (q_full)
                begin
                    status_next = rrss_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en         = 1'b1;
                    tail_ptr_next = tail_inc;
                    count_next    = count_reg + CW'(1);
                end
            end
            else if (q_empty)
            begin
                status_next = rrss_pkg::STATUS_EMPTY;
            end
            else
            begin
                // Pop the head. An unfinished task goes back to the tail,
                // which always has room since its own entry was just freed.
                head_ptr_next = head_inc;
                time_next     = time_reg + {24'd0, slice_len};
                if (done)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_entry.id    = head_entry.id;
                    wr_entry.burst = rem_burst;
                    tail_ptr_next  = tail_inc;
                end
                ran_id_next = head_entry.id;
                slice_next  = slice_len;
                rem_next    = rem_burst;
                fin_next    = done;
                etime_next  = time_reg + {24'd0, slice_len};
            end
        end
    end

    // The response register is held while the consumer stalls.
    always_comb
    begin
        if (adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            ran_id_reg <= ran_id_next;
            slice_reg  <= slice_next;
            rem_reg    <= rem_next;
            fin_reg    <= fin_next;
            etime_reg  <= etime_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.ran_task_id     = ran_id_reg;
    assign rsp.slice_length    = slice_reg;
    assign rsp.remaining_burst = rem_reg;
    assign rsp.finished        = fin_reg;
    assign rsp.elapsed_time    = etime_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("task count exceeds queue depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("empty queue with head and tail apart");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (s1_cmd_reg == rrss_pkg::CMD_ADD) && !q_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted add did not grow the queue");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (s1_cmd_reg == rrss_pkg::CMD_SLICE) && q_empty)
        |=> (rsp.valid && (rsp.status == rrss_pkg::STATUS_EMPTY)))
        else $error("slice on empty queue not reported");

    a_fin_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.finished) |-> (rsp.remaining_burst == '0))
        else $error("finished task with time left");

endmodule

FILE: test/rrss_checker.sv
module rrss_checker
    import rrss_pkg::*;
#(
    parameter int         QUEUE_DEPTH  = 64,
    parameter logic [2:0] QUANTUM_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    rrss_req_if         req,
    rrss_rsp_if         rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    id;
        logic [SLICE_W-1:0] slice;
        logic [BURST_W-1:0] rem;
        logic               fin;
        logic [TIME_W-1:0]  elapsed;
    } sched_report_t;

    sched_report_t      sched_reports[$];
    logic [ID_W-1:0]    ready_ids[QUEUE_DEPTH];
    logic [BURST_W-1:0] ready_bursts[QUEUE_DEPTH];
    int unsigned        head_slot;
    int unsigned        tail_slot;
    int unsigned        task_count;
    logic [TIME_W-1:0]  elapsed;
    logic [SLICE_W-1:0] quantum;
    int                 fail_count = 0;

    assign mismatches = fail_count;

    function automatic int unsigned next_slot(input int unsigned p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic void enqueue(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] b);
        ready_ids[tail_slot]    = id;
        ready_bursts[tail_slot] = b;
        tail_slot               = next_slot(tail_slot);
        task_count++;
    endfunction

    // Applies one request word to the shadow queue and returns the report it causes.
    function automatic sched_report_t schedule_word(input logic c,
                                                    input logic [ID_W-1:0] id_in,
                                                    input logic [BURST_W-1:0] burst_in);
        sched_report_t      r;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] b;
        logic [BURST_W-1:0] run_len;
        logic [BURST_W-1:0] rem;
        r = '0;
        if (c == CMD_ADD) begin
            if (task_count >= QUEUE_DEPTH)
                r.status = STATUS_FULL;
            else
                enqueue(id_in, burst_in);
        end else if (task_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            id         = ready_ids[head_slot];
            b          = ready_bursts[head_slot];
            run_len    = (b < {8'd0, quantum}) ? b : {8'd0, quantum};
            rem        = b - run_len;
            head_slot  = next_slot(head_slot);
            task_count--;
            elapsed    = elapsed + TIME_W'(run_len);
            // A task that still needs time takes the slot its own pop just freed.
            if (rem != 0)
                enqueue(id, rem);
            r.status  = STATUS_OK;
            r.id      = id;
            r.slice   = run_len[SLICE_W-1:0];
            r.rem     = rem;
            r.fin     = (rem == 0);
            r.elapsed = elapsed;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sched_report_t seen;
        sched_report_t want;
        if (!rst_n) begin
            head_slot  = 0;
            tail_slot  = 0;
            task_count = 0;
            elapsed    = '0;
            quantum    = QUANTUM_RESET;
            sched_reports.delete();
            outstanding <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                seen.status  = rsp.status;
                seen.id      = rsp.ran_task_id;
                seen.slice   = rsp.slice_length;
                seen.rem     = rsp.remaining_burst;
                seen.fin     = rsp.finished;
                seen.elapsed = rsp.elapsed_time;
                if (sched_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response word with nothing pending: status=%0d id=%0d",
                                 $realtime, seen.status, seen.id);
                end else begin
                    want = sched_reports.pop_front();
                    if (seen.status !== want.status || seen.id !== want.id ||
                        seen.slice !== want.slice || seen.rem !== want.rem ||
                        seen.fin !== want.fin || seen.elapsed !== want.elapsed) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch: expected status=%0d id=%0d slice=%0d ",
                                      "rem=%0d fin=%0d time=%0d, got status=%0d id=%0d ",
                                      "slice=%0d rem=%0d fin=%0d time=%0d"},
                                     $realtime, want.status, want.id, want.slice, want.rem,
                                     want.fin, want.elapsed, seen.status, seen.id,
                                     seen.slice, seen.rem, seen.fin, seen.elapsed);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == QUANTUM_ADDR)
                quantum = pwdata[SLICE_W-1:0];
            if (req.valid && req.ready)
                sched_reports.push_back(schedule_word(req.cmd, req.task_id, req.burst));
            outstanding <= sched_reports.size();
        end
    end

endmodule

FILE: test/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrss_pkg::*;

    localparam int         QUEUE_DEPTH  = 64;
    // Register map: the quantum is register zero; the next word address holds no register.
    localparam logic [2:0] QUANTUM_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR   = 3'd4;
    localparam int         NUM_PHASES   = 7;
    localparam int         PHASE_WORDS  = 150;
    // The limit leaves ample margin over the slowest legal run.
    localparam int         CYCLE_LIMIT  = 400000;

    // Command mix of one stretch of random words. A run of add-heavy words fills the queue
    // until adds bounce with a full status; a slice-heavy run drains it to empty.
    typedef enum int {MIX_ADDS, MIX_SLICES, MIX_EVEN} mix_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left  = 0;

    rrss_req_if req_ch ();
    rrss_rsp_if rsp_ch ();

    round_robin_slice_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker shadows the queue from the accepted words and the register writes,
    // and compares every response word against its own prediction.
    rrss_checker #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .QUANTUM_ADDR (QUANTUM_ADDR)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake or a lost response word ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** round_robin_slice_scheduler: FAILED **");
            $finish;
        end
    end

    // The receiver switches between a few stall patterns: always ready, mostly ready,
    // a fixed one-in-five stall, and long stalls where it takes a word only now and then.
    int stall_mode = 0;
    int mode_left  = 0;
    int beat       = 0;

    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        beat++;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= (beat % 5 != 4);
            default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Offers one request word and returns at the edge where it is taken, or after the gap
    // that closes a burst. The sender works in bursts: valid stays high across the words of
    // a burst, and when a burst ends it drops valid for a gap before the next burst starts.
    task automatic send_word(input logic c, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] b);
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= c;
        req_ch.task_id <= id;
        req_ch.burst   <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6))
                @(posedge clk);
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Holds the sender off until every response word has come back, which leaves the
    // block idle: register writes are only made after this.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // APB write: a setup phase, then the access phase, which completes on pready.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [SLICE_W-1:0] phase_quantum[NUM_PHASES];
        mix_t               mix;
        int                 run_left;
        int                 pick;
        logic               c;
        logic [BURST_W-1:0] b;

        run_left = 0;
        mix      = MIX_EVEN;

        // Every input of the block is known from time zero.
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_ADD;
        req_ch.task_id = '0;
        req_ch.burst   = '0;
        rsp_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the quantum left at its reset value of ten.
        // A slice on the empty queue reports empty and changes nothing.
        send_word(CMD_SLICE, 8'h00, 16'h0000);
        // Extremes of the id and the burst, a zero burst, and bursts right at and just
        // above the quantum.
        send_word(CMD_ADD, 8'h00, 16'd1);
        send_word(CMD_ADD, 8'hFF, 16'hFFFF);
        send_word(CMD_ADD, 8'hA5, 16'd0);
        send_word(CMD_ADD, 8'h5A, 16'd10);
        send_word(CMD_ADD, 8'h3C, 16'd11);
        // Runs: a one-unit task finishes, the long one is cut to a quantum and requeued,
        // the zero-burst task finishes with a zero slice, the exact fit finishes, and the
        // one just above is clamped to a last single unit on its second turn.
        repeat (7)
            send_word(CMD_SLICE, 8'h00, 16'h0000);

        // Largest quantum.
        drain();
        write_reg(QUANTUM_ADDR, 32'd255);
        send_word(CMD_ADD, 8'h81, 16'd300);
        repeat (3)
            send_word(CMD_SLICE, 8'hFF, 16'hFFFF);

        // Smallest nonzero quantum.
        drain();
        write_reg(QUANTUM_ADDR, 32'd1);
        repeat (2)
            send_word(CMD_SLICE, 8'h00, 16'h0000);

        // A zero quantum: slices of length zero, time stands still, tasks go back unchanged.
        drain();
        write_reg(QUANTUM_ADDR, 32'd0);
        repeat (2)
            send_word(CMD_SLICE, 8'h00, 16'h0000);

        // A write to the address past the last register must leave the quantum at zero.
        drain();
        write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
        send_word(CMD_SLICE, 8'h00, 16'h0000);

        // Random part: one quantum per phase, the extremes among them.
        phase_quantum[0] = 8'd255;
        phase_quantum[1] = 8'd1;
        phase_quantum[2] = SLICE_W'($urandom_range(2, 254));
        phase_quantum[3] = 8'd0;
        phase_quantum[4] = QUANTUM_RESET;
        phase_quantum[5] = SLICE_W'($urandom_range(0, 255));
        phase_quantum[6] = 8'd3;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_reg(QUANTUM_ADDR, {24'd0, phase_quantum[ph]});
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (run_left == 0) begin
                    mix      = mix_t'($urandom_range(0, 2));
                    run_left = $urandom_range(10, 90);
                end
                run_left--;
                pick = $urandom_range(0, 9);
                case (mix)
                    MIX_ADDS:   c = (pick < 2) ? CMD_SLICE : CMD_ADD;
                    MIX_SLICES: c = (pick < 8) ? CMD_SLICE : CMD_ADD;
                    default:    c = (pick < 5) ? CMD_SLICE : CMD_ADD;
                endcase
                // Mostly short bursts so tasks finish within a few slices; some zero,
                // some at the maximum and some over the full range.
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    b = 16'd0;
                else if (pick < 8)
                    b = 16'hFFFF;
                else if (pick < 14)
                    b = BURST_W'($urandom_range(0, 65535));
                else if (pick < 30)
                    b = BURST_W'($urandom_range(1, 600));
                else
                    b = BURST_W'($urandom_range(1, 40));
                send_word(c, ID_W'($urandom_range(0, 255)), b);
            end
        end

        // Wait for the last response words and for anything stray that may follow.
        drain();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("** round_robin_slice_scheduler: PASSED **");
        else
            $display("** round_robin_slice_scheduler: FAILED **");
        $finish;
    end

endmodule
